// ===== rtl/core/rstp_port_transmit_fsm_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the RSTP port transmit machine
// Concurrent assertion wrappers clocked on aclk; compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef RSTP_PORT_TRANSMIT_FSM_ASSERT_SVH
`define RSTP_PORT_TRANSMIT_FSM_ASSERT_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define RSTP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// checked at every edge, reset included
`define RSTP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);
`else
`define RSTP_ASSERT(lbl, prop, msg)
`define RSTP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/rstp_tx_pkg.sv =====
// ----------------------------------------------------------------------------
// RSTP port transmit package
// States, action and role codes, BPDU kinds and shared types.
// ----------------------------------------------------------------------------
package rstp_tx_pkg;

    // transmit machine states
    typedef enum logic [2:0] {
        ST_INIT     = 3'd0,
        ST_IDLE     = 3'd1,
        ST_PERIODIC = 3'd2,
        ST_CONFIG   = 3'd3,
        ST_TCN      = 3'd4,
        ST_RSTP     = 3'd5
    } tx_state_t;

    // action codes carried in tuser
    localparam logic [2:0] ACT_BEGIN      = 3'd0;
    localparam logic [2:0] ACT_EVALUATE   = 3'd1;
    localparam logic [2:0] ACT_TICK       = 3'd2;
    localparam logic [2:0] ACT_SET_NEW    = 3'd3;
    localparam logic [2:0] ACT_SET_TC_ACK = 3'd4;

    // port roles
    localparam logic [2:0] ROLE_DISABLED = 3'd0;
    localparam logic [2:0] ROLE_RT       = 3'd1;
    localparam logic [2:0] ROLE_DESIG    = 3'd2;
    localparam logic [2:0] ROLE_ALT      = 3'd3;
    localparam logic [2:0] ROLE_BK       = 3'd4;

    // BPDU role field encoding
    localparam logic [1:0] RCODE_UNKNOWN = 2'd0;
    localparam logic [1:0] RCODE_ALT_BK  = 2'd1;
    localparam logic [1:0] RCODE_ROOT    = 2'd2;
    localparam logic [1:0] RCODE_DESIG   = 2'd3;

    // BPDU kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_CONFIG = 2'd1;
    localparam logic [1:0] KIND_TCN    = 2'd2;
    localparam logic [1:0] KIND_RSTP   = 2'd3;

    // configuration register indexes and reset values
    localparam logic CFG_HELLO_TIME = 1'b0;
    localparam logic CFG_TX_HOLD    = 1'b1;
    localparam logic [3:0] HELLO_TIME_RST = 4'd2;
    localparam logic [3:0] TX_HOLD_RST    = 4'd6;
    localparam logic [3:0] TX_COUNT_MAX   = 4'd15;

    // machine variables
    typedef struct packed {
        tx_state_t  machine_state;
        logic       entry_done;
        logic       new_info;
        logic [3:0] tx_count;
        logic [3:0] hello_when;
        logic       tc_ack;
    } tx_vars_t;

    // one input transaction
    typedef struct packed {
        logic [2:0] action;
        logic       send_rstp;
        logic       selected;
        logic       updt_info;
        logic [2:0] port_role;
        logic       tc_while_active;
        logic       agree;
        logic       proposing;
        logic       learning;
        logic       forwarding;
    } tx_item_t;

    // BPDU report of one step
    typedef struct packed {
        logic [1:0] tx_kind;
        logic [7:0] bpdu_flags;
    } tx_bpdu_t;

    function automatic logic [1:0] role_code(input logic [2:0] role);
        logic [1:0] code;
        code = RCODE_UNKNOWN;
        if (role == ROLE_ALT || role == ROLE_BK) begin
            code = RCODE_ALT_BK;
        end else if (role == ROLE_RT) begin
            code = RCODE_ROOT;
        end else if (role == ROLE_DESIG) begin
            code = RCODE_DESIG;
        end
        return code;
    endfunction

endpackage

// ===== rtl/core/rstp_tx_eval.sv =====
// ----------------------------------------------------------------------------
// RSTP transmit step logic
// Next machine variables and BPDU report for one action.
// ----------------------------------------------------------------------------
module rstp_tx_eval
    import rstp_tx_pkg::*;
(
    input  tx_vars_t   vars,
    input  tx_item_t   item,
    input  logic [3:0] hello_time,
    input  logic [3:0] tx_hold_count,
    output tx_vars_t   vars_next,
    output tx_bpdu_t   bpdu
);

    logic [3:0] hello_eff;
    logic       gate;
    logic       cond;
    logic [3:0] tx_inc;

    // idle entry loads hello timer once; send conditions
    assign hello_eff = vars.entry_done ? vars.hello_when : hello_time;
    assign gate      = item.selected && !item.updt_info;
    assign cond      = gate && vars.new_info && (vars.tx_count < tx_hold_count)
                       && (hello_eff != 4'd0);
    assign tx_inc    = (vars.tx_count == TX_COUNT_MAX) ? vars.tx_count
                                                       : vars.tx_count + 4'd1;

    // next machine variables
    always_comb begin
        vars_next = vars;
        unique case (item.action)
            ACT_BEGIN: begin
                vars_next.machine_state = ST_INIT;
                vars_next.entry_done    = 1'b0;
            end
            ACT_TICK: begin
                if (vars.hello_when != 4'd0) vars_next.hello_when = vars.hello_when - 4'd1;
                if (vars.tx_count != 4'd0) vars_next.tx_count = vars.tx_count - 4'd1;
            end
            ACT_SET_NEW: begin
                vars_next.new_info = 1'b1;
            end
            ACT_SET_TC_ACK: begin
                vars_next.tc_ack = 1'b1;
            end
            ACT_EVALUATE: begin
                unique case (vars.machine_state)
                    ST_IDLE: begin
                        vars_next.hello_when = hello_eff;
                        vars_next.entry_done = 1'b0;
                        priority if (item.send_rstp && cond) begin
                            vars_next.machine_state = ST_RSTP;
                        end else if (!item.send_rstp && item.port_role == ROLE_RT
                                     && cond) begin
                            vars_next.machine_state = ST_TCN;
                        end else if (!item.send_rstp && item.port_role == ROLE_DESIG
                                     && cond) begin
                            vars_next.machine_state = ST_CONFIG;
                        end else if (gate && hello_eff == 4'd0) begin
                            vars_next.machine_state = ST_PERIODIC;
                        end else begin
                            vars_next.entry_done = 1'b1;
                        end
                    end
                    ST_PERIODIC: begin
                        if (item.port_role == ROLE_DESIG
                            || (item.port_role == ROLE_RT && item.tc_while_active)) begin
                            vars_next.new_info = 1'b1;
                        end
                        vars_next.machine_state = ST_IDLE;
                        vars_next.entry_done    = 1'b0;
                    end
                    ST_CONFIG, ST_RSTP: begin
                        vars_next.new_info      = 1'b0;
                        vars_next.tx_count      = tx_inc;
                        vars_next.machine_state = ST_IDLE;
                        vars_next.entry_done    = 1'b0;
                        vars_next.tc_ack        = 1'b0;
                    end
                    ST_TCN: begin
                        vars_next.new_info      = 1'b0;
                        vars_next.tx_count      = tx_inc;
                        vars_next.machine_state = ST_IDLE;
                        vars_next.entry_done    = 1'b0;
                    end
                    default: begin
                        // init, and any stray code
                        vars_next.new_info      = 1'b1;
                        vars_next.tx_count      = 4'd0;
                        vars_next.machine_state = ST_IDLE;
                        vars_next.entry_done    = 1'b0;
                    end
                endcase
            end
            default: begin
                // unused action codes leave everything alone
            end
        endcase
    end

    // BPDU kind and flags byte
    always_comb begin
        bpdu.tx_kind    = KIND_NONE;
        bpdu.bpdu_flags = 8'h00;
        if (item.action == ACT_EVALUATE) begin
            unique case (vars.machine_state)
                ST_CONFIG: begin
                    bpdu.tx_kind    = KIND_CONFIG;
                    bpdu.bpdu_flags = {vars.tc_ack, 6'b0, item.tc_while_active};
                end
                ST_TCN: begin
                    bpdu.tx_kind = KIND_TCN;
                end
                ST_RSTP: begin
                    bpdu.tx_kind    = KIND_RSTP;
                    bpdu.bpdu_flags = {1'b0, item.agree, item.forwarding, item.learning,
                                       role_code(item.port_role), item.proposing,
                                       item.tc_while_active};
                end
                default: begin
                    // no transmission from init, idle or periodic
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/rstp_port_transmit_fsm.sv =====
// ----------------------------------------------------------------------------
// RSTP port transmit machine
// Spanning-tree port transmit state machine with hello and transmit counters.
// ----------------------------------------------------------------------------
// One action per input transaction (begin, evaluate, tick, set new info, set
// tc ack) steps the transmit machine and yields exactly one result: the BPDU
// kind and flags byte sent by that step, plus the machine state, transmit
// count and new-info flag afterwards. The block takes one transaction per
// cycle while results are taken; a result passes the input register, one
// pass of the step logic, and the result register. A stalled result holds
// the input register and so stalls the input. Machine variables update in
// the step stage, so consecutive transactions see each other's effect.
// Configuration writes take effect at once and must be made by the user
// while no transaction is in flight; the block does not enforce this.
module rstp_port_transmit_fsm
    import rstp_tx_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [3:0]  cfg_wdata,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] send_rstp, [1] selected, [2] updt_info, [5:3] port_role,
    // [6] tc_while_active, [7] agree, [8] proposing, [9] learning,
    // [10] forwarding, [15:11] zero
    input  logic [15:0] s_tdata,
    // [2:0] action
    input  logic [2:0]  s_tuser,
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] bpdu_flags, [10:8] fsm_state, [14:11] tx_count_now,
    // [15] new_info_now
    output logic [15:0] m_tdata,
    // [1:0] tx_kind
    output logic [1:0]  m_tuser
);

    logic [3:0] hello_time_reg;
    logic [3:0] tx_hold_reg;
    logic       in_valid_reg;
    tx_item_t   in_item_reg;
    logic       out_valid_reg;
    logic [15:0] out_data_reg;
    logic [1:0] out_kind_reg;
    tx_vars_t   vars_reg;
    tx_vars_t   vars_next;
    tx_bpdu_t   bpdu;
    logic       out_free;
    logic       fire;

    // handshake: the result register frees the step stage
    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hello_time_reg <= HELLO_TIME_RST;
            tx_hold_reg    <= TX_HOLD_RST;
        end else if (cfg_we) begin
            if (cfg_addr == CFG_HELLO_TIME) hello_time_reg <= cfg_wdata;
            if (cfg_addr == CFG_TX_HOLD) tx_hold_reg <= cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= tx_item_t'({s_tuser, s_tdata[0], s_tdata[1], s_tdata[2],
                                       s_tdata[5:3], s_tdata[6], s_tdata[7],
                                       s_tdata[8], s_tdata[9], s_tdata[10]});
        end
    end

    // step logic
    rstp_tx_eval u_eval (
        .vars          (vars_reg),
        .item          (in_item_reg),
        .hello_time    (hello_time_reg),
        .tx_hold_count (tx_hold_reg),
        .vars_next     (vars_next),
        .bpdu          (bpdu)
    );

    // machine variables
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vars_reg <= '{machine_state: ST_INIT, entry_done: 1'b0, new_info: 1'b0,
                          tx_count: 4'd0, hello_when: 4'd0, tc_ack: 1'b0};
        end else if (fire) begin
            vars_reg <= vars_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_kind_reg <= bpdu.tx_kind;
            out_data_reg <= {vars_next.new_info, vars_next.tx_count,
                             vars_next.machine_state, bpdu.bpdu_flags};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

    // checks
    `include "rstp_port_transmit_fsm_assert.svh"

    `RSTP_ASSERT(a_quiet_flags, m_tvalid && (m_tuser == KIND_NONE || m_tuser == KIND_TCN) |-> m_tdata[7:0] == 8'h00, "flags set without a flagged BPDU")
    `RSTP_ASSERT(a_send_to_idle, m_tvalid && m_tuser != KIND_NONE |-> m_tdata[10:8] == ST_IDLE, "transmit step did not return to idle")
    `RSTP_ASSERT(a_count_holds, !fire |=> $stable(vars_reg), "machine variables changed without a step")
    `RSTP_ASSERT_ALWAYS(a_reset_state, !aresetn |=> vars_reg.machine_state == ST_INIT && !m_tvalid && !in_valid_reg, "reset did not clear the machine")

endmodule

// ===== tb/rstp_port_transmit_checker.sv =====
// ----------------------------------------------------------------------------
// RSTP port transmit checker
// Watches the configuration port and both stream channels. Each accepted
// input transaction steps a local copy of the transmit machine; each accepted
// result is compared field by field with the oldest predicted report.
// ----------------------------------------------------------------------------
module rstp_port_transmit_checker
    import rstp_tx_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          fail_count,
    output int          pending
);

    // one predicted step report
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] flags;
        tx_state_t  state;
        logic [3:0] count;
        logic       new_info;
    } port_tx_report_t;

    // local copy of the machine and its registers
    tx_state_t  st;
    logic       entry_done;
    logic       new_info;
    logic [3:0] tx_count;
    logic [3:0] hello_when;
    logic       tc_ack;
    logic [3:0] hello_time;
    logic [3:0] tx_hold;

    port_tx_report_t pending_reports[$];
    int n_mismatch = 0;
    int n_results  = 0;

    assign fail_count = n_mismatch;

    function automatic void clear_port_tx();
        st         = ST_INIT;
        entry_done = 1'b0;
        new_info   = 1'b0;
        tx_count   = '0;
        hello_when = '0;
        tc_ack     = 1'b0;
        hello_time = HELLO_TIME_RST;
        tx_hold    = TX_HOLD_RST;
    endfunction

    // common tail of every transmit state
    function automatic void count_bpdu();
        new_info = 1'b0;
        if (tx_count != TX_COUNT_MAX) tx_count = tx_count + 4'd1;
        st         = ST_IDLE;
        entry_done = 1'b0;
    endfunction

    // advance the machine by one action and return its report
    function automatic port_tx_report_t step_port_tx(input tx_item_t it);
        port_tx_report_t r;
        logic            gate;
        logic            cond;
        logic [1:0]      rcode;
        r.kind  = KIND_NONE;
        r.flags = '0;
        case (it.action)
            ACT_BEGIN: begin
                st         = ST_INIT;
                entry_done = 1'b0;
            end
            ACT_TICK: begin
                if (hello_when != 0) hello_when = hello_when - 4'd1;
                if (tx_count != 0) tx_count = tx_count - 4'd1;
            end
            ACT_SET_NEW: begin
                new_info = 1'b1;
            end
            ACT_SET_TC_ACK: begin
                tc_ack = 1'b1;
            end
            ACT_EVALUATE: begin
                case (st)
                    ST_IDLE: begin
                        gate = it.selected && !it.updt_info;
                        // hello timer reloads only on a fresh entry
                        if (!entry_done) hello_when = hello_time;
                        cond = gate && new_info && (tx_count < tx_hold) && (hello_when != 0);
                        entry_done = 1'b0;
                        if (it.send_rstp && cond) begin
                            st = ST_RSTP;
                        end else if (!it.send_rstp && it.port_role == ROLE_RT && cond) begin
                            st = ST_TCN;
                        end else if (!it.send_rstp && it.port_role == ROLE_DESIG && cond) begin
                            st = ST_CONFIG;
                        end else if (gate && hello_when == 0) begin
                            st = ST_PERIODIC;
                        end else begin
                            entry_done = 1'b1;
                        end
                    end
                    ST_PERIODIC: begin
                        if (it.port_role == ROLE_DESIG ||
                            (it.port_role == ROLE_RT && it.tc_while_active)) begin
                            new_info = 1'b1;
                        end
                        st         = ST_IDLE;
                        entry_done = 1'b0;
                    end
                    ST_CONFIG: begin
                        r.kind  = KIND_CONFIG;
                        r.flags = {tc_ack, 6'b0, it.tc_while_active};
                        count_bpdu();
                        tc_ack = 1'b0;
                    end
                    ST_TCN: begin
                        r.kind = KIND_TCN;
                        count_bpdu();
                    end
                    ST_RSTP: begin
                        case (it.port_role)
                            ROLE_ALT, ROLE_BK: rcode = RCODE_ALT_BK;
                            ROLE_RT:           rcode = RCODE_ROOT;
                            ROLE_DESIG:        rcode = RCODE_DESIG;
                            default:           rcode = RCODE_UNKNOWN;
                        endcase
                        r.kind  = KIND_RSTP;
                        r.flags = {1'b0, it.agree, it.forwarding, it.learning, rcode,
                                   it.proposing, it.tc_while_active};
                        count_bpdu();
                        tc_ack = 1'b0;
                    end
                    default: begin
                        // init actions
                        new_info   = 1'b1;
                        tx_count   = '0;
                        st         = ST_IDLE;
                        entry_done = 1'b0;
                    end
                endcase
            end
            default: ;
        endcase
        r.state    = st;
        r.count    = tx_count;
        r.new_info = new_info;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        n_mismatch++;
        // keep the log bounded on a badly broken block
        if (n_mismatch <= 100) begin
            $display("mismatch on result %0d, %s: got %0h, want %0h",
                     n_results, what, got, want);
        end
    endtask

    // monitor both channels and the register port
    always @(posedge aclk) begin : monitor
        tx_item_t        it;
        port_tx_report_t want;
        if (!aresetn) begin
            clear_port_tx();
            pending_reports.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_addr == CFG_HELLO_TIME) hello_time = cfg_wdata;
                else tx_hold = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                it.action          = s_tuser;
                it.send_rstp       = s_tdata[0];
                it.selected        = s_tdata[1];
                it.updt_info       = s_tdata[2];
                it.port_role       = s_tdata[5:3];
                it.tc_while_active = s_tdata[6];
                it.agree           = s_tdata[7];
                it.proposing       = s_tdata[8];
                it.learning        = s_tdata[9];
                it.forwarding      = s_tdata[10];
                pending_reports.push_back(step_port_tx(it));
            end
            if (m_tvalid && m_tready) begin
                if (pending_reports.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata, '0);
                end else begin
                    want = pending_reports.pop_front();
                    if (m_tuser !== want.kind)
                        report_mismatch("tx_kind", 16'(m_tuser), 16'(want.kind));
                    if (m_tdata[7:0] !== want.flags)
                        report_mismatch("bpdu_flags", 16'(m_tdata[7:0]), 16'(want.flags));
                    if (m_tdata[10:8] !== want.state)
                        report_mismatch("fsm_state", 16'(m_tdata[10:8]), 16'(want.state));
                    if (m_tdata[14:11] !== want.count)
                        report_mismatch("tx_count_now", 16'(m_tdata[14:11]),
                                        16'(want.count));
                    if (m_tdata[15] !== want.new_info)
                        report_mismatch("new_info_now", 16'(m_tdata[15]),
                                        16'(want.new_info));
                end
                n_results++;
            end
        end
        pending <= pending_reports.size();
    end

endmodule

// ===== tb/rstp_port_transmit_fsm_tb.sv =====
// ----------------------------------------------------------------------------
// RSTP port transmit testbench
// Drives the transmit machine with a directed walk through every state and
// BPDU kind, then random action sequences under several register settings,
// with random gaps and result stalls. The checker predicts and compares.
// ----------------------------------------------------------------------------
module rstp_port_transmit_fsm_tb;
    import rstp_tx_pkg::*;

    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         SETTLE       = 6;
    localparam int         PHASE_ITEMS  = 88;
    localparam logic [2:0] ACT_RSVD_LO  = 3'd5;
    localparam logic [2:0] ACT_RSVD_HI  = 3'd7;
    localparam logic [2:0] ROLE_UNDEF   = 3'd7;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_addr  = 1'b0;
    logic [3:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    // [0] send_rstp, [1] selected, [2] updt_info, [5:3] port_role,
    // [6] tc_while_active, [7] agree, [8] proposing, [9] learning,
    // [10] forwarding, [15:11] zero
    logic [15:0] s_tdata   = '0;
    // [2:0] action
    logic [2:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    // [7:0] bpdu_flags, [10:8] fsm_state, [14:11] tx_count_now, [15] new_info_now
    logic [15:0] m_tdata;
    // [1:0] tx_kind
    logic [1:0]  m_tuser;

    int   fail_count;
    int   pending;
    int   cycle_cnt = 0;
    logic calm      = 1'b0;

    // register settings per random phase
    logic [3:0] hello_plan [6] = '{4'd1, 4'd10, 4'd0, 4'd4, 4'd2, 4'd7};
    logic [3:0] hold_plan  [6] = '{4'd10, 4'd1, 4'd6, 4'd3, 4'd10, 4'd2};

    rstp_port_transmit_fsm i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    rstp_port_transmit_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // timeout guard
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result-side stalls
    always @(posedge aclk) begin
        if (calm) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 99) >= 17);
    end

    // selected, not updating; adv = {forwarding, learning, proposing, agree}
    function automatic tx_item_t mk_txn(input logic [2:0] action, input logic rstp,
                                        input logic [2:0] role, input logic tcw,
                                        input logic [3:0] adv);
        tx_item_t t;
        t.action          = action;
        t.send_rstp       = rstp;
        t.selected        = 1'b1;
        t.updt_info       = 1'b0;
        t.port_role       = role;
        t.tc_while_active = tcw;
        t.agree           = adv[0];
        t.proposing       = adv[1];
        t.learning        = adv[2];
        t.forwarding      = adv[3];
        return t;
    endfunction

    // mostly well-formed action traffic with some noise
    function automatic tx_item_t rand_txn();
        tx_item_t t;
        int       r;
        r = $urandom_range(0, 99);
        if (r < 4)       t.action = ACT_BEGIN;
        else if (r < 52) t.action = ACT_EVALUATE;
        else if (r < 67) t.action = ACT_TICK;
        else if (r < 82) t.action = ACT_SET_NEW;
        else if (r < 91) t.action = ACT_SET_TC_ACK;
        else t.action = 3'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI));
        t.send_rstp = 1'($urandom_range(0, 1));
        t.selected  = ($urandom_range(0, 99) < 88);
        t.updt_info = ($urandom_range(0, 99) < 12);
        if ($urandom_range(0, 99) < 60)
            t.port_role = $urandom_range(0, 1) ? ROLE_RT : ROLE_DESIG;
        else
            t.port_role = 3'($urandom_range(0, 7));
        t.tc_while_active = 1'($urandom_range(0, 1));
        t.agree           = 1'($urandom_range(0, 1));
        t.proposing       = 1'($urandom_range(0, 1));
        t.learning        = 1'($urandom_range(0, 1));
        t.forwarding      = 1'($urandom_range(0, 1));
        return t;
    endfunction

    // offer one transaction, with an occasional gap ahead of it
    task automatic send_txn(input tx_item_t t);
        if (!calm && $urandom_range(0, 99) < 17) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= t.action;
        s_tdata  <= {5'b0, t.forwarding, t.learning, t.proposing, t.agree,
                     t.tc_while_active, t.port_role, t.updt_info, t.selected,
                     t.send_rstp};
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold off until every predicted report has come, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_regs(input logic [3:0] hello, input logic [3:0] hold);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_HELLO_TIME;
        cfg_wdata <= hello;
        @(posedge aclk);
        cfg_addr  <= CFG_TX_HOLD;
        cfg_wdata <= hold;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        tx_item_t t;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed walk at reset settings
        send_txn(mk_txn(ACT_EVALUATE, 1'b0, ROLE_DESIG, 1'b0, 4'h0));   // init -> idle
        send_txn(mk_txn(ACT_SET_TC_ACK, 1'b0, ROLE_DESIG, 1'b0, 4'h0));
        send_txn(mk_txn(ACT_EVALUATE, 1'b0, ROLE_DESIG, 1'b0, 4'h0));   // -> config
        send_txn(mk_txn(ACT_EVALUATE, 1'b0, ROLE_DESIG, 1'b1, 4'hF));   // config BPDU, TC+TCA
        t = mk_txn(ACT_EVALUATE, 1'b0, ROLE_DESIG, 1'b0, 4'h0);
        t.updt_info = 1'b1;
        send_txn(t);                                                    // update pending
        send_txn(mk_txn(ACT_SET_NEW, 1'b0, ROLE_RT, 1'b0, 4'h0));
        t = mk_txn(ACT_EVALUATE, 1'b0, ROLE_RT, 1'b0, 4'h0);
        t.selected = 1'b0;
        send_txn(t);                                                    // not selected
        send_txn(mk_txn(ACT_EVALUATE, 1'b0, ROLE_RT, 1'b0, 4'h0));      // -> tcn
        send_txn(mk_txn(ACT_EVALUATE, 1'b0, ROLE_RT, 1'b1, 4'hF));      // TCN BPDU
        send_txn(mk_txn(ACT_SET_NEW, 1'b1, ROLE_ALT, 1'b0, 4'h0));
        send_txn(mk_txn(ACT_EVALUATE, 1'b1, ROLE_ALT, 1'b0, 4'h0));     // -> rstp
        send_txn(mk_txn(ACT_EVALUATE, 1'b1, ROLE_ALT, 1'b1, 4'hF));     // all flags
        send_txn(mk_txn(ACT_SET_NEW, 1'b1, ROLE_BK, 1'b0, 4'h0));
        send_txn(mk_txn(ACT_EVALUATE, 1'b1, ROLE_BK, 1'b0, 4'h0));
        send_txn(mk_txn(ACT_EVALUATE, 1'b1, ROLE_UNDEF, 1'b0, 4'h5));   // unknown role
        send_txn(mk_txn(ACT_SET_NEW, 1'b1, ROLE_DISABLED, 1'b0, 4'h0));
        send_txn(mk_txn(ACT_EVALUATE, 1'b1, ROLE_DESIG, 1'b0, 4'h0));
        send_txn(mk_txn(ACT_EVALUATE, 1'b1, ROLE_DISABLED, 1'b1, 4'hA));
        send_txn(mk_txn(ACT_EVALUATE, 1'b0, ROLE_DESIG, 1'b0, 4'h0));   // idle, nothing new
        send_txn(mk_txn(ACT_TICK, 1'b0, ROLE_DESIG, 1'b0, 4'h0));
        send_txn(mk_txn(ACT_TICK, 1'b0, ROLE_DESIG, 1'b0, 4'h0));
        send_txn(mk_txn(ACT_TICK, 1'b0, ROLE_DESIG, 1'b0, 4'h0));       // held at zero
        send_txn(mk_txn(ACT_EVALUATE, 1'b0, ROLE_DESIG, 1'b0, 4'h0));   // -> periodic
        send_txn(mk_txn(ACT_EVALUATE, 1'b0, ROLE_RT, 1'b1, 4'h0));      // root with tc
        send_txn(mk_txn(ACT_RSVD_LO, 1'b1, ROLE_RT, 1'b1, 4'hF));
        send_txn(mk_txn(ACT_RSVD_HI, 1'b1, ROLE_RT, 1'b1, 4'hF));
        send_txn(mk_txn(ACT_BEGIN, 1'b0, ROLE_DESIG, 1'b0, 4'h0));

        // random phases, each under its own register setting
        for (int p = 0; p < 6; p++) begin
            drain();
            write_regs(hello_plan[p], hold_plan[p]);
            calm <= (p == 2);
            repeat (PHASE_ITEMS) send_txn(rand_txn());
        end
        drain();

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== rstp_port_transmit_fsm.f =====
+incdir+rtl/core
rtl/core/rstp_tx_pkg.sv
rtl/core/rstp_tx_eval.sv
rtl/core/rstp_port_transmit_fsm.sv
tb/rstp_port_transmit_checker.sv
tb/rstp_port_transmit_fsm_tb.sv
